@@ sv/table_linear_interpolator_macros.svh @@
// Assertion macros for the table linear interpolator.
`ifndef TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define TLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that an antecedent implies a consequent in the next cycle.
`define TLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/tli_pkg.sv @@
// Package: operation and status codes and the front-to-back command type.
`default_nettype none
package tli_pkg;
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Classified item as handed from front to back.
    typedef struct packed {
        logic        is_query;   // needs the table search
        logic [1:0]  status;     // final status for non-queries
        logic [31:0] key;
    } t_cmd;
endpackage
`default_nettype wire

@@ sv/tli_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/tli_fifo.sv @@
// Two-entry command queue between the front and the back.
`default_nettype none
module tli_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  tli_pkg::t_cmd     i_cmd,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output tli_pkg::t_cmd     o_cmd
);
    import tli_pkg::*;
    `include "table_linear_interpolator_macros.svh"

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_slot[r_wp] <= i_cmd;
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];

    `TLI_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "push to full queue")
    `TLI_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `TLI_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "queue count out of range")
endmodule
`default_nettype wire

@@ sv/tli_front.sv @@
// Front: accepts items, updates the table and the point count, classifies.
`default_nettype none
module tli_front #(
    parameter int TABLE_DEPTH = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [1:0]   i_operation,
    input  wire logic [31:0]  i_key_in,
    input  wire logic         i_q_full,
    input  wire logic         i_back_busy,
    output logic              o_push,
    output tli_pkg::t_cmd     o_cmd,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [CW-1:0]     o_count
);
    import tli_pkg::*;

    logic [CW-1:0] r_count;
    logic          acc, full;

    // A table change waits until no queued query can still read the table.
    assign o_stall = i_q_full || ((i_operation == OP_CLEAR || i_operation == OP_APPEND)
                                  && i_back_busy);
    assign acc     = i_valid && !o_stall;
    assign full    = (r_count == CW'(TABLE_DEPTH));

    always_comb begin
        o_cmd.key      = i_key_in;
        o_cmd.is_query = 1'b0;
        o_cmd.status   = ST_OK;
        case (i_operation)
            OP_APPEND: if (full) o_cmd.status = ST_FULL;
            OP_QUERY: begin
                if (r_count == '0) o_cmd.status = ST_EMPTY;
                else               o_cmd.is_query = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_push  = acc;
    assign o_we    = acc && i_operation == OP_APPEND && !full;
    assign o_waddr = r_count[AW-1:0];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (acc) begin
            if (i_operation == OP_CLEAR) r_count <= '0;
            else if (o_we)               r_count <= r_count + 1'b1;
        end
    end
endmodule
`default_nettype wire

@@ sv/tli_back.sv @@
// Back: table search, product, restoring division, saturation, output register.
`default_nettype none
module tli_back #(
    parameter int AW = 6,
    parameter int CW = 7,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_valid,
    input  tli_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output logic              o_busy,
    input  wire logic [CW-1:0] i_count,
    output logic [AW-1:0]     o_raddr,
    input  wire logic [DATA_WIDTH-1:0] i_kdata,
    input  wire logic [DATA_WIDTH-1:0] i_vdata,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [31:0]       o_result_value,
    output logic [1:0]        o_status
);
    import tli_pkg::*;
    `include "table_linear_interpolator_macros.svh"

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW + 2;
    localparam int QCW = $clog2(PW + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // issue read
    localparam logic [3:0] S_WAIT  = 4'd2;  // read latency
    localparam logic [3:0] S_CHK   = 4'd3;  // compare with key
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0]  r_st;
    logic [CW-1:0] r_idx;
    logic        r_last_done;
    logic signed [DW-1:0] r_x, r_x1, r_y1, r_x2, r_y2, x_q;
    logic signed [DW:0]   r_res;
    logic        r_neg;
    logic [DW:0] r_mag, r_dx, r_dw;
    logic [PW-1:0] r_prod, r_rem;
    logic [QCW-1:0] r_bit;
    logic [PW-1:0] r_quo;
    logic        r_ovalid;
    logic [31:0] r_oval;
    logic [1:0]  r_ostat;
    logic        out_free;
    logic signed [DW-1:0] kd, vd;
    logic [PW-1:0] rem_sh;
    logic [PW-1:0] prod_w;
    logic signed [DW+1:0] sum;
    logic signed [DW-1:0] maxv, minv;

    assign kd   = i_kdata;
    assign vd   = i_vdata;
    assign x_q  = DW'($signed(i_cmd.key));
    assign out_free = !r_ovalid || !i_stall;
    assign maxv = {1'b0, {(DW-1){1'b1}}};
    assign minv = {1'b1, {(DW-1){1'b0}}};
    assign o_busy = i_q_valid || r_st != S_IDLE;
    assign o_pop  = (r_st == S_OUT) && out_free;
    assign o_raddr = r_idx[AW-1:0];
    assign rem_sh = {r_rem[PW-2:0], r_prod[PW-1]};
    assign prod_w = r_mag * r_dx;
    assign sum = r_neg ? (DW+2)'(r_y1) - (DW+2)'(signed'({1'b0, r_quo[DW:0]}))
                       : (DW+2)'(r_y1) + (DW+2)'(signed'({1'b0, r_quo[DW:0]}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // Raise on a finished item, hold while stalled, drop once taken.
            r_ovalid <= o_pop || (r_ovalid && i_stall);
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_res <= '0;
                    if (i_cmd.is_query) begin
                        r_idx       <= '0;
                        r_last_done <= 1'b0;
                        r_st        <= S_RD;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_RD:   r_st <= S_WAIT;
                S_WAIT: r_st <= S_CHK;
                S_CHK: begin
                    // Entry 0: below or equal first key; last entry: at/above last.
                    if (r_idx == '0 && x_q <= kd) begin
                        r_res <= (DW+1)'(vd); r_st <= S_OUT;
                    end else if (r_idx == i_count - 1'b1 && x_q >= kd) begin
                        r_res <= (DW+1)'(vd); r_st <= S_OUT;
                    end else if (r_idx == '0) begin
                        // Hold the first point, then check the last one.
                        r_x1 <= kd; r_y1 <= vd;
                        r_idx <= i_count - 1'b1; r_st <= S_RD;
                    end else if (r_idx == i_count - 1'b1 && !r_last_done) begin
                        // Last checked; start scan from entry one.
                        r_last_done <= 1'b1; r_idx <= CW'(1); r_st <= S_RD;
                    end else if (x_q < kd) begin
                        r_x2 <= kd; r_y2 <= vd; r_st <= S_MUL;
                    end else if (r_idx + 1'b1 >= i_count) begin
                        r_st <= S_OUT;
                    end else begin
                        r_x1 <= kd; r_y1 <= vd;
                        r_idx <= r_idx + 1'b1; r_st <= S_RD;
                    end
                end
                S_MUL: begin
                    r_neg  <= (r_y2 < r_y1);
                    r_mag  <= (r_y2 < r_y1) ? (DW+1)'(r_y1) - (DW+1)'(r_y2)
                                             : (DW+1)'(r_y2) - (DW+1)'(r_y1);
                    r_dx   <= (DW+1)'(x_q) - (DW+1)'(r_x1);
                    r_dw   <= (DW+1)'(r_x2) - (DW+1)'(r_x1);
                    r_st   <= S_FIN;
                end
                S_FIN: begin
                    // Product of two (DW+1)-bit magnitudes; start the divider.
                    r_prod <= prod_w;
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_bit  <= QCW'(PW);
                    r_st   <= S_DIV;
                end
                S_DIV: begin
                    if (r_bit == '0) begin
                        if (sum > (DW+2)'(maxv))      r_res <= (DW+1)'(maxv);
                        else if (sum < (DW+2)'(minv)) r_res <= (DW+1)'(minv);
                        else                          r_res <= (DW+1)'(sum);
                        r_st <= S_OUT;
                    end else begin
                        r_prod <= {r_prod[PW-2:0], 1'b0};
                        if (rem_sh >= PW'(r_dw)) begin
                            r_rem <= rem_sh - PW'(r_dw);
                            r_quo <= {r_quo[PW-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[PW-2:0], 1'b0};
                        end
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_OUT: if (out_free) begin
                    r_oval   <= 32'(r_res[DW-1:0]);
                    r_ostat  <= i_cmd.status;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_result_value = r_oval;
    assign o_status       = r_ostat;

    `TLI_ASSERT_IMP(a_pop_has_item, i_clk, i_rst_n, o_pop, i_q_valid, "pop without queued item")
    `TLI_ASSERT_NEXT(a_out_after_pop, i_clk, i_rst_n, o_pop, o_valid, "pop without result")
    `TLI_ASSERT_IMP(a_busy_state, i_clk, i_rst_n, r_st != S_IDLE, o_busy, "busy flag low while working")
endmodule
`default_nettype wire

@@ sv/table_linear_interpolator.sv @@
// Top level of the table linear interpolator: front, command queue, back, tables.
// Piecewise linear table interpolator over up to TABLE_DEPTH (key, value)
// points in signed Q16.16. Operation 0 clears the table, 1 appends a point
// (status 2 when full), 2 queries (status 1 on an empty table). Every item
// yields exactly one result item. A clear or append waits until the back has
// finished all queued queries, since it changes the table that they read, and
// then passes through the queue and the back's output state to the output
// register; the next table change can be taken once that result is there. A
// query visits table points in a linear scan (each visit is one registered
// RAM read through the read, wait and compare states; the first and the last
// point are visited before the scan from point one), then runs a set-up and
// the bit-serial restoring divider; the scan and the divider take most of its
// time. Queries enter a two-item queue, so until it is full the input keeps
// taking them while the back works or while a finished result waits in the
// output register; a clear or append holds until the queue and back are idle.
`default_nettype none
module table_linear_interpolator #(
    parameter int TABLE_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_key_in,
    input  wire logic [31:0] i_value_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_result_value,
    output logic [1:0]       o_status
);
    import tli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_cmd              push_cmd, q_cmd;
    logic              push, q_full, q_valid, pop, back_busy, we;
    logic [AW-1:0]     waddr, raddr;
    logic [CW-1:0]     count;
    logic [DATA_WIDTH-1:0] kdata, vdata;

    tli_front #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW), .CW(CW)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_operation, .i_key_in,
        .i_q_full(q_full), .i_back_busy(back_busy), .o_push(push),
        .o_cmd(push_cmd), .o_we(we), .o_waddr(waddr), .o_count(count)
    );

    tli_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(push_cmd), .o_full(q_full),
        .i_pop(pop), .o_valid(q_valid), .o_cmd(q_cmd)
    );

    // Key and value tables; entries above the count are never read.
    tli_ram #(.WIDTH(DATA_WIDTH), .DEPTH(TABLE_DEPTH)) u_keys (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(DATA_WIDTH'($signed(i_key_in))),
        .i_raddr(raddr), .o_rdata(kdata)
    );
    tli_ram #(.WIDTH(DATA_WIDTH), .DEPTH(TABLE_DEPTH)) u_vals (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(DATA_WIDTH'($signed(i_value_in))),
        .i_raddr(raddr), .o_rdata(vdata)
    );

    tli_back #(.AW(AW), .CW(CW), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_cmd(q_cmd), .o_pop(pop),
        .o_busy(back_busy), .i_count(count), .o_raddr(raddr),
        .i_kdata(kdata), .i_vdata(vdata), .o_valid, .i_stall,
        .o_result_value, .o_status
    );
endmodule
`default_nettype wire
